/* design/tone_pattern_sequencer_assert.svh */
// assertion macros for the tone pattern sequencer checker
`ifndef TONE_PATTERN_SEQUENCER_ASSERT_SVH
`define TONE_PATTERN_SEQUENCER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define TPS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tone pattern sequencer check failed");

// consequent must hold in the cycle after the antecedent
`define TPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tone pattern sequencer check failed");

`endif

/* design/tps_pkg.sv */
// package: types, codes and pattern rom of the tone pattern sequencer
package tps_pkg;

	localparam int STEPS     = 16;
	localparam int PATTERNS  = 8;
	localparam int ROM_STEPS = 16;
	localparam int ROM_PATS  = 8;

	localparam logic [2:0]  PAT_TEST      = 3'd0;
	localparam logic [2:0]  PAT_SILENT    = 3'd2;
	localparam logic [2:0]  PAT_TRIGGERED = 3'd7;

	localparam logic [14:0] ELAPSED_MAX  = 15'h7FFF;
	localparam logic [3:0]  RESTART_MAX  = 4'hF;
	localparam logic [3:0]  LIMIT_RESET  = 4'd5;

	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_PLAY  = 2'd1,
		MODE_QUEUE = 2'd2
	} tps_mode_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [2:0] pattern_id;
	} tps_req_t;

	typedef struct packed {
		logic [4:0] step_number;
		logic [2:0] active_pattern;
		logic       cycle_ended;
		logic       buzzer_on;
	} tps_result_t;

	// pattern rom
	localparam logic [4:0] PAT_LEN [ROM_PATS] = '{
		5'd2, 5'd4, 5'd16, 5'd2, 5'd6, 5'd6, 5'd2, 5'd16
	};

	localparam logic [15:0] PAT_ON [ROM_PATS] = '{
		16'h0001, 16'h000A, 16'h0000, 16'h0002,
		16'h0015, 16'h0015, 16'h0001, 16'h5555
	};

	localparam logic [ROM_PATS-1:0] PAT_SINGLE = 8'b0000_1011;

	localparam logic [14:0] PAT_DUR [ROM_PATS][ROM_STEPS] = '{
		'{15'd400, 15'd400, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0,
		  15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0},
		'{15'd200, 15'd200, 15'd200, 15'd200, 15'd0, 15'd0, 15'd0, 15'd0,
		  15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0},
		'{15'd100, 15'd100, 15'd100, 15'd100, 15'd100, 15'd100, 15'd100, 15'd100,
		  15'd100, 15'd100, 15'd100, 15'd100, 15'd100, 15'd100, 15'd100, 15'd100},
		'{15'd200, 15'd200, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0,
		  15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0},
		'{15'd100, 15'd100, 15'd100, 15'd100, 15'd100, 15'd4500, 15'd0, 15'd0,
		  15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0},
		'{15'd300, 15'd100, 15'd300, 15'd100, 15'd300, 15'd3900, 15'd0, 15'd0,
		  15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0},
		'{15'd200, 15'd19800, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0,
		  15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0},
		'{15'd200, 15'd180, 15'd180, 15'd160, 15'd160, 15'd140, 15'd140, 15'd120,
		  15'd120, 15'd100, 15'd100, 15'd80, 15'd80, 15'd60, 15'd60, 15'd40}
	};

	// out-of-range index falls back to silence
	function automatic logic [2:0] tps_valid_id(input logic [2:0] id);
		if (int'(id) >= PATTERNS || int'(id) >= ROM_PATS)
			return PAT_SILENT;
		return id;
	endfunction

	// step count, capped at the configured and stored maximum
	function automatic logic [4:0] tps_steps(input logic [2:0] id);
		logic [4:0] n;
		n = PAT_LEN[id];
		if (int'(n) > STEPS)
			n = 5'(STEPS);
		if (int'(n) > ROM_STEPS)
			n = 5'(ROM_STEPS);
		return n;
	endfunction

endpackage

/* design/tps_core.sv */
// sequencer state and single-pass next-state logic
module tps_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [3:0]            cfg_data,
	input  logic                  req_acc,
	input  tps_pkg::tps_req_t     req,
	output tps_pkg::tps_result_t  res
);

	logic [4:0]  phase_q,    phase_d;
	logic [14:0] elapsed_q,  elapsed_d;
	logic [3:0]  restarts_q, restarts_d;
	logic [2:0]  cur_q,      cur_d;
	logic [2:0]  next_q,     next_d;
	logic        pin_q,      pin_d;
	logic        ended_q,    ended_d;
	logic [3:0]  limit_q;

	always_comb begin
		logic       load_req;
		logic [2:0] load_id;
		logic [2:0] id_ok;
		logic [3:0] k;
		logic [4:0] len;

		phase_d    = phase_q;
		elapsed_d  = elapsed_q;
		restarts_d = restarts_q;
		cur_d      = cur_q;
		next_d     = next_q;
		pin_d      = pin_q;
		ended_d    = ended_q;
		load_req   = 1'b0;
		load_id    = tps_pkg::PAT_SILENT;
		id_ok      = tps_pkg::tps_valid_id(req.pattern_id);
		len        = tps_pkg::tps_steps(cur_q);
		k          = '0;

		unique case (req.mode)
			tps_pkg::MODE_TICK: begin
				if (elapsed_q != tps_pkg::ELAPSED_MAX)
					elapsed_d = elapsed_q + 15'd1;
				if (phase_q == 5'd0) begin
					elapsed_d = '0;
					phase_d   = 5'd1;
					ended_d   = (cur_q == tps_pkg::PAT_SILENT);
				end
				k = 4'(phase_d - 5'd1);
				if (phase_d >= len + 5'd1) begin
					// pattern finished: reload
					phase_d  = '0;
					ended_d  = 1'b1;
					load_req = 1'b1;
					if (tps_pkg::PAT_SINGLE[cur_q]) begin
						next_d  = tps_pkg::PAT_SILENT;
						load_id = tps_pkg::PAT_SILENT;
					end else begin
						load_id = next_q;
					end
				end else if (elapsed_d > tps_pkg::PAT_DUR[cur_q][k]) begin
					elapsed_d = '0;
					phase_d   = phase_d + 5'd1;
				end else begin
					pin_d = tps_pkg::PAT_ON[cur_q][k];
				end
			end
			tps_pkg::MODE_PLAY: begin
				load_req = 1'b1;
				load_id  = id_ok;
			end
			tps_pkg::MODE_QUEUE: begin
				next_d = id_ok;
			end
			default: begin
			end
		endcase

		if (load_req) begin
			if (cur_q == tps_pkg::PAT_TRIGGERED && restarts_q != tps_pkg::RESTART_MAX)
				restarts_d = restarts_q + 4'd1;
			cur_d   = (restarts_d >= limit_q) ? tps_pkg::PAT_SILENT : load_id;
			phase_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= '0;
			elapsed_q  <= '0;
			restarts_q <= '0;
			cur_q      <= tps_pkg::PAT_TEST;
			next_q     <= tps_pkg::PAT_SILENT;
			pin_q      <= 1'b0;
			ended_q    <= 1'b1;
			limit_q    <= tps_pkg::LIMIT_RESET;
		end else begin
			if (cfg_we)
				limit_q <= cfg_data;
			if (req_acc) begin
				phase_q    <= phase_d;
				elapsed_q  <= elapsed_d;
				restarts_q <= restarts_d;
				cur_q      <= cur_d;
				next_q     <= next_d;
				pin_q      <= pin_d;
				ended_q    <= ended_d;
			end
		end
	end

	// result reflects the state after the request
	assign res.buzzer_on      = pin_d;
	assign res.cycle_ended    = ended_d;
	assign res.active_pattern = cur_d;
	assign res.step_number    = phase_d;

endmodule

/* design/tone_pattern_sequencer.sv */
// top level of the tone pattern sequencer with output buffering
// Plays timed on/off buzzer patterns from an eight-entry built-in rom. Each
// request on the slave side is a tick of one millisecond, a play of a pattern
// or a queue of the next pattern, and gives exactly one result on the master
// side: pin level, cycle-ended flag, active pattern and step number, all as
// they stand after that request. One request is taken per clock cycle while
// s_tready is high: the whole update is one pass of counter, rom and compare
// logic into the state registers. Results sit in an output register backed by
// a one-entry skid register, so s_tready depends only on registered state and
// falls only when both are full. The repeat limit for the triggered pattern is
// written through the cfg channel, which is always ready; write it only while
// no request is in flight.
module tone_pattern_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: triggered repeat limit
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [2:0] pattern_id, rest zero
	input  logic [1:0]  s_tuser,   // [1:0] mode
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // [0] buzzer_on, [1] cycle_ended,
	                               // [4:2] active_pattern, [9:5] step_number
);

	tps_pkg::tps_req_t    req;
	tps_pkg::tps_result_t res;
	tps_pkg::tps_result_t out_q, skid_q;
	logic                 out_valid_q, skid_valid_q;
	logic                 req_acc, res_take;

	assign cfg_ready = 1'b1;
	assign s_tready  = !skid_valid_q;
	assign req_acc   = s_tvalid && s_tready;
	assign res_take  = out_valid_q && m_tready;

	assign req.mode       = s_tuser;
	assign req.pattern_id = s_tdata[2:0];

	tps_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.req_acc  (req_acc),
		.req      (req),
		.res      (res)
	);

	// output register and skid occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (res_take) begin
				if (skid_valid_q)
					skid_valid_q <= 1'b0;
				else
					out_valid_q <= req_acc;
			end else if (req_acc) begin
				if (!out_valid_q)
					out_valid_q <= 1'b1;
				else
					skid_valid_q <= 1'b1;
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (res_take) begin
			if (skid_valid_q)
				out_q <= skid_q;
			else if (req_acc)
				out_q <= res;
		end else if (req_acc) begin
			if (!out_valid_q)
				out_q <= res;
			else
				skid_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_q};

endmodule

/* design/tps_checker.sv */
// port-level checker for the tone pattern sequencer, bound to the top level
`include "tone_pattern_sequencer_assert.svh"

module tps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata
);

	// a stalled result holds
	`TPS_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
	// an accepted request always leaves a result waiting
	`TPS_ASSERT_NEXT(a_req_res, clk, arst_n, s_tvalid && s_tready, m_tvalid)
	// back-pressure on the request side only when a result is waiting
	`TPS_ASSERT_SAME(a_bp, clk, arst_n, !s_tready, m_tvalid)
	// step number never goes past the finishing step, padding stays zero
	`TPS_ASSERT_SAME(a_step, clk, arst_n, m_tvalid, m_tdata[9:5] <= 5'd17 && m_tdata[15:10] == 6'd0)

endmodule

bind tone_pattern_sequencer tps_checker u_tps_checker (.*);
